// File: rtl/lis_pkg.sv
package lis_pkg;

    localparam int MAX_LEN    = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_LEN);
    localparam int LEN_BITS   = $clog2(MAX_LEN + 1);

    // comparison token that walks the chain once per loaded item
    typedef struct packed {
        logic                  vld;
        logic [VALUE_BITS-1:0] val;
        logic [LEN_BITS-1:0]   len;
        logic [LEN_BITS-1:0]   link;
    } t_tok;

    // one stored position: value, best run ending here, predecessor plus one
    typedef struct packed {
        logic [VALUE_BITS-1:0] val;
        logic [LEN_BITS-1:0]   len;
        logic [LEN_BITS-1:0]   pred;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INGEST,
        ST_TRACE
    } t_state;

endpackage

// File: rtl/lis_cell.sv
module lis_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [lis_pkg::IDX_BITS-1:0]  i_index,
    input  logic [lis_pkg::LEN_BITS-1:0]  i_count,
    input  lis_pkg::t_tok                 i_tok,
    input  logic                          i_shift,
    input  lis_pkg::t_entry               i_prev,
    output lis_pkg::t_tok                 o_tok,
    output lis_pkg::t_entry               o_entry
);
    import lis_pkg::*;

    t_tok   r_tok;
    t_tok   n_tok;
    t_entry r_ent;
    logic   w_filled;
    logic   w_hit;

    assign w_filled = LEN_BITS'(i_index) < i_count;
    assign w_hit    = (LEN_BITS'(i_index) == i_count);

    always_comb begin
        n_tok = i_tok;
        // extend the run through this position if it is smaller and longer
        if (i_tok.vld && w_filled && (r_ent.val < i_tok.val)
                && (r_ent.len + 1'b1 > i_tok.len)) begin
            n_tok.len  = r_ent.len + 1'b1;
            n_tok.link = LEN_BITS'(i_index) + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok.vld <= n_tok.vld;
        end
        r_tok.val  <= n_tok.val;
        r_tok.len  <= n_tok.len;
        r_tok.link <= n_tok.link;

        if (i_shift) begin
            r_ent <= i_prev;
        end else if (i_tok.vld && w_hit) begin
            r_ent.val  <= i_tok.val;
            r_ent.len  <= i_tok.len;
            r_ent.pred <= i_tok.link;
        end
    end

    assign o_tok   = r_tok;
    assign o_entry = r_ent;

endmodule

// File: rtl/longest_increasing_subsequence_unit.sv
// Longest strictly increasing subsequence over a loaded sequence.
// Input channel: i_valid / o_stall carry one value per item, with
// i_end_of_sequence set on the last one. Up to 64 values are kept; later
// values are dropped, but an end flag on a dropped value still starts output.
// For each stored value, a comparison token walks the row of 64
// cells, one cell per cycle, and the last cell hands back its length.
// o_stall is high for the whole of that walk, so one item is taken at a time.
// After the flagged item the cell row shifts toward its top end once per
// cycle and each member of the subsequence is caught as it passes, from the
// end position back to the earliest one. Output: o_valid / i_stall, one
// member per item, with o_last_result on the earliest member. While i_stall
// holds a waiting result and the next member sits in the top cell, the
// shift freezes. After the last member the block is idle and ready for a
// new sequence. Reset empties the sequence and drops any pending result.
module longest_increasing_subsequence_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_value,
    input  logic        i_end_of_sequence,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_position,
    output logic [15:0] o_member_value,
    output logic [6:0]  o_subsequence_length,
    output logic        o_last_result
);
    import lis_pkg::*;

    t_state                r_state, n_state;
    logic [LEN_BITS-1:0]   r_count, n_count;
    logic [LEN_BITS-1:0]   r_best_len, n_best_len;
    logic [IDX_BITS-1:0]   r_best_end, n_best_end;
    logic                  r_eos, n_eos;
    logic [IDX_BITS-1:0]   r_target, n_target;
    logic [IDX_BITS-1:0]   r_top, n_top;
    logic [LEN_BITS-1:0]   r_emitted, n_emitted;
    logic                  r_ovalid, n_ovalid;
    logic [5:0]            r_opos, n_opos;
    logic [15:0]           r_oval, n_oval;
    logic [6:0]            r_olen, n_olen;
    logic                  r_olast, n_olast;

    t_tok                  w_tok [MAX_LEN+1];
    t_entry                w_ent [MAX_LEN];
    t_entry                w_ent_zero;
    logic                  w_accept;
    logic                  w_start;
    logic                  w_shift;
    logic                  w_match;
    logic                  w_out_free;
    logic                  w_last;
    t_tok                  w_exit;
    t_entry                w_top_ent;

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_exit     = w_tok[MAX_LEN];
    assign w_top_ent  = w_ent[MAX_LEN-1];
    assign w_ent_zero = '0;
    assign w_match    = (r_top == r_target);
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_last     = (w_top_ent.pred == '0)
                        || (LEN_BITS'(r_emitted + 1'b1) >= r_best_len);

    assign w_tok[0].vld  = w_start;
    assign w_tok[0].val  = i_value[VALUE_BITS-1:0];
    assign w_tok[0].len  = LEN_BITS'(1);
    assign w_tok[0].link = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_LEN; k++) begin : g_cell
            lis_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_BITS'(k)),
                .i_count (r_count),
                .i_tok   (w_tok[k]),
                .i_shift (w_shift),
                .i_prev  ((k == 0) ? w_ent_zero : w_ent[(k == 0) ? 0 : k-1]),
                .o_tok   (w_tok[k+1]),
                .o_entry (w_ent[k])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_best_len = r_best_len;
        n_best_end = r_best_end;
        n_eos      = r_eos;
        n_target   = r_target;
        n_top      = r_top;
        n_emitted  = r_emitted;
        n_ovalid   = r_ovalid && i_stall;
        n_opos     = r_opos;
        n_oval     = r_oval;
        n_olen     = r_olen;
        n_olast    = r_olast;
        w_start    = 1'b0;
        w_shift    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (r_count < LEN_BITS'(MAX_LEN)) begin
                        w_start = 1'b1;
                        n_eos   = i_end_of_sequence;
                        n_state = ST_INGEST;
                    end else if (i_end_of_sequence) begin
                        // drop the value, read out what is stored
                        n_target  = r_best_end;
                        n_top     = IDX_BITS'(MAX_LEN - 1);
                        n_emitted = '0;
                        n_state   = ST_TRACE;
                    end
                end
            end
            ST_INGEST: begin
                if (w_exit.vld) begin
                    n_count = r_count + 1'b1;
                    if (w_exit.len > r_best_len) begin
                        n_best_len = w_exit.len;
                        n_best_end = r_count[IDX_BITS-1:0];
                    end
                    if (r_eos) begin
                        n_target  = n_best_end;
                        n_top     = IDX_BITS'(MAX_LEN - 1);
                        n_emitted = '0;
                        n_state   = ST_TRACE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TRACE: begin
                // hold the row while a member waits for a full output register
                w_shift = !(w_match && !w_out_free);
                if (w_shift) begin
                    n_top = r_top - 1'b1;
                end
                if (w_match && w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_opos    = 6'(r_top);
                    n_oval    = 16'(w_top_ent.val);
                    n_olen    = 7'(r_best_len);
                    n_olast   = w_last;
                    n_emitted = r_emitted + 1'b1;
                    n_target  = IDX_BITS'(w_top_ent.pred - 1'b1);
                    if (w_last) begin
                        n_count    = '0;
                        n_best_len = '0;
                        n_best_end = '0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_best_len <= '0;
            r_best_end <= '0;
            r_eos      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_best_len <= n_best_len;
            r_best_end <= n_best_end;
            r_eos      <= n_eos;
            r_ovalid   <= n_ovalid;
        end
        r_target  <= n_target;
        r_top     <= n_top;
        r_emitted <= n_emitted;
        r_opos    <= n_opos;
        r_oval    <= n_oval;
        r_olen    <= n_olen;
        r_olast   <= n_olast;
    end

    assign o_stall              = (r_state != ST_IDLE);
    assign o_valid              = r_ovalid;
    assign o_position           = r_opos;
    assign o_member_value       = r_oval;
    assign o_subsequence_length = r_olen;
    assign o_last_result        = r_olast;

    a_tok_exit_in_ingest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> (r_state == ST_INGEST))
        else $error("comparison token left the row outside ingest");

    a_best_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best_len <= r_count)
        else $error("best length exceeds loaded count");

    a_top_above_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRACE) |-> (r_top >= r_target))
        else $error("traceback target passed the row top");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_TRACE) && w_match && w_out_free && w_last)
        |=> ((r_count == '0) && (r_best_len == '0) && o_valid && o_last_result))
        else $error("sequence not cleared after final member");

endmodule
